// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the single-wire bus master core.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

	// Command codes carried by the func field of a tick.
	localparam logic [1:0] FUNC_NONE      = 2'd0;
	localparam logic [1:0] FUNC_BUS_RESET = 2'd1;
	localparam logic [1:0] FUNC_WRITE     = 2'd2;
	localparam logic [1:0] FUNC_READ      = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PHASE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

	// Write data is as wide as the widest supported timer.
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values, in ticks.
	localparam int unsigned DEF_RESET_LOW     = 495;
	localparam int unsigned DEF_PRESENCE_WAIT = 65;
	localparam int unsigned DEF_SHORT_PHASE   = 2;
	localparam int unsigned DEF_LONG_PHASE    = 65;
	localparam int unsigned DEF_RECOVERY      = 3;
	localparam int unsigned DEF_READ_SAMPLE   = 15;
	localparam int unsigned DEF_READ_TAIL     = 45;

	// Classified operation as seen by the sequencer.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_BUS_RESET,
		OP_WRITE,
		OP_READ
	} op_t;

	// One classified tick, as it travels through the queue.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       level;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/owbm_if.sv =====
// ----------------------------------------------------------------------------
// owbm_if
// Valid/ready channels of the single-wire bus master core.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       bus_level;

	modport source (output valid, func, data_byte, bus_level, input ready);
	modport sink   (input valid, func, data_byte, bus_level, output ready);
endinterface

interface owbm_result_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_data;

	modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
		input ready);
	modport sink   (input valid, drive_low, busy_res, done_res, presence, read_data,
		output ready);
endinterface

interface owbm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [owbm_pkg::CFG_IDX_W-1:0]      index;
	logic [owbm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front
// Accepts ticks, decodes the command and holds the result in one stage.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	owbm_tick_if.sink          tick,
	output owbm_pkg::cmd_t     item,
	output logic               item_valid,
	input  wire logic          item_ready
);

	owbm_pkg::cmd_t cmd_s1;
	logic           valid_s1;
	owbm_pkg::op_t  op_dec;

	always_comb begin
		case (tick.func)
			owbm_pkg::FUNC_BUS_RESET: op_dec = owbm_pkg::OP_BUS_RESET;
			owbm_pkg::FUNC_WRITE:     op_dec = owbm_pkg::OP_WRITE;
			owbm_pkg::FUNC_READ:      op_dec = owbm_pkg::OP_READ;
			default:                  op_dec = owbm_pkg::OP_NONE;
		endcase
	end

	// The stage refills in the same cycle it drains.
	assign tick.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			cmd_s1.op    <= op_dec;
			cmd_s1.data  <= tick.data_byte;
			cmd_s1.level <= tick.bus_level;
		end
	end

	assign item       = cmd_s1;
	assign item_valid = valid_s1;

endmodule

`default_nettype wire

// ===== sv/owbm_queue.sv =====
// ----------------------------------------------------------------------------
// owbm_queue
// Two-entry queue between the command front end and the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire owbm_pkg::cmd_t push_item,
	input  wire logic          push_valid,
	output logic               push_ready,
	output owbm_pkg::cmd_t     pop_item,
	output logic               pop_valid,
	input  wire logic          pop_ready
);

	owbm_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/owbm_engine.sv =====
// ----------------------------------------------------------------------------
// owbm_engine
// Bus slot sequencer, timing registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_engine #(
	parameter int unsigned TIMER_BITS = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire owbm_pkg::cmd_t item,
	input  wire logic          item_valid,
	output logic               item_ready,
	owbm_cfg_if.sink           cfg,
	owbm_result_if.source      result
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_W_HIGH   = 4'd3;
	localparam logic [3:0] PH_W_LOW    = 4'd4;
	localparam logic [3:0] PH_W_REL    = 4'd5;
	localparam logic [3:0] PH_W_REC    = 4'd6;
	localparam logic [3:0] PH_R_HIGH   = 4'd7;
	localparam logic [3:0] PH_R_LOW    = 4'd8;
	localparam logic [3:0] PH_R_SAMPLE = 4'd9;
	localparam logic [3:0] PH_R_TAIL   = 4'd10;

	logic [TIMER_BITS-1:0] reset_low_q, presence_wait_q, short_phase_q, long_phase_q;
	logic [TIMER_BITS-1:0] recovery_q, read_sample_q, read_tail_q;

	logic [3:0]            phase_q, phase_n;
	logic [TIMER_BITS-1:0] tick_q, tick_n, tick_inc, len_sel;
	logic [2:0]            bit_q, bit_n;
	logic [7:0]            shift_q, shift_n, read_q, read_n;
	logic                  pres_q, pres_n;
	logic                  done_c, cur_bit, over, step;
	logic                  out_valid_q;

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= TIMER_BITS'(owbm_pkg::DEF_RESET_LOW);
			presence_wait_q <= TIMER_BITS'(owbm_pkg::DEF_PRESENCE_WAIT);
			short_phase_q   <= TIMER_BITS'(owbm_pkg::DEF_SHORT_PHASE);
			long_phase_q    <= TIMER_BITS'(owbm_pkg::DEF_LONG_PHASE);
			recovery_q      <= TIMER_BITS'(owbm_pkg::DEF_RECOVERY);
			read_sample_q   <= TIMER_BITS'(owbm_pkg::DEF_READ_SAMPLE);
			read_tail_q     <= TIMER_BITS'(owbm_pkg::DEF_READ_TAIL);
		end else if (cfg.valid) begin
			case (cfg.index)
				owbm_pkg::REG_RESET_LOW:     reset_low_q     <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_PRESENCE_WAIT: presence_wait_q <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_SHORT_PHASE:   short_phase_q   <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_LONG_PHASE:    long_phase_q    <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_RECOVERY:      recovery_q      <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_READ_SAMPLE:   read_sample_q   <= cfg.data[TIMER_BITS-1:0];
				owbm_pkg::REG_READ_TAIL:     read_tail_q     <= cfg.data[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cur_bit = shift_q[bit_q];

	// Length of the phase now running.
	always_comb begin
		case (phase_q)
			PH_RST_LOW:  len_sel = reset_low_q;
			PH_RST_WAIT: len_sel = presence_wait_q;
			PH_W_LOW:    len_sel = cur_bit ? short_phase_q : long_phase_q;
			PH_W_REL:    len_sel = cur_bit ? long_phase_q : short_phase_q;
			PH_W_REC:    len_sel = recovery_q;
			PH_R_LOW:    len_sel = short_phase_q;
			PH_R_SAMPLE: len_sel = read_sample_q;
			PH_R_TAIL:   len_sel = read_tail_q;
			default:     len_sel = '0;
		endcase
	end

	// A zero length behaves like one tick.
	assign over     = ({1'b0, tick_q} + (TIMER_BITS+1)'(1)) >= {1'b0, len_sel};
	assign tick_inc = tick_q + TIMER_BITS'(1);

	always_comb begin
		phase_n = phase_q;
		tick_n  = over ? '0 : tick_inc;
		bit_n   = bit_q;
		shift_n = shift_q;
		read_n  = read_q;
		pres_n  = pres_q;
		done_c  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				tick_n = '0;
				case (item.op)
					owbm_pkg::OP_BUS_RESET: phase_n = PH_RST_LOW;
					owbm_pkg::OP_WRITE: begin
						shift_n = item.data;
						bit_n   = 3'd0;
						phase_n = PH_W_HIGH;
					end
					owbm_pkg::OP_READ: begin
						shift_n = 8'd0;
						bit_n   = 3'd0;
						phase_n = PH_R_HIGH;
					end
					default: ;
				endcase
			end
			PH_RST_LOW: begin
				if (over) phase_n = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (over) begin
					pres_n  = !item.level;
					phase_n = PH_IDLE;
					done_c  = 1'b1;
				end
			end
			PH_W_HIGH: begin
				tick_n = '0;
				if (item.level) phase_n = PH_W_LOW;
			end
			PH_W_LOW: begin
				if (over) phase_n = PH_W_REL;
			end
			PH_W_REL: begin
				if (over) phase_n = PH_W_REC;
			end
			PH_W_REC: begin
				if (over) begin
					if (bit_q == 3'd7) begin
						phase_n = PH_IDLE;
						done_c  = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_W_LOW;
					end
				end
			end
			PH_R_HIGH: begin
				tick_n = '0;
				if (item.level) phase_n = PH_R_LOW;
			end
			PH_R_LOW: begin
				if (over) phase_n = PH_R_SAMPLE;
			end
			PH_R_SAMPLE: begin
				if (over) begin
					shift_n[bit_q] = shift_q[bit_q] | item.level;
					phase_n        = PH_R_TAIL;
				end
			end
			PH_R_TAIL: begin
				if (over) begin
					if (bit_q == 3'd7) begin
						read_n  = shift_q;
						phase_n = PH_IDLE;
						done_c  = 1'b1;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_R_LOW;
					end
				end
			end
			default: begin
				tick_n  = '0;
				phase_n = PH_IDLE;
			end
		endcase
	end

	// One tick is executed whenever the output register can take its result.
	assign item_ready = !out_valid_q || result.ready;
	assign step       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			read_q      <= 8'd0;
			pres_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				read_q  <= read_n;
				pres_q  <= pres_n;
			end
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result.drive_low <= (phase_n == PH_RST_LOW) || (phase_n == PH_W_LOW)
				|| (phase_n == PH_R_LOW);
			result.busy_res  <= (phase_n != PH_IDLE);
			result.done_res  <= done_c;
			result.presence  <= pres_n;
			result.read_data <= read_n;
		end
	end

	assign result.valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: single-wire bus master, one tick per transfer.
// A result is registered in the front end, the queue and the output register
// after its tick transfer. Throughput: one tick per cycle unless the result
// channel stalls. Reset clears all control.
// ----------------------------------------------------------------------------
`default_nettype none

// Each tick transfer carries one microsecond of bus time: the command, the byte
// to write and the sampled wire level. Every tick produces exactly one result
// transfer with the pin drive, busy, done, presence and last read byte.
//
// The front end registers and decodes the tick. A two-entry queue lets the
// front end keep taking ticks while the result side is stalled, until the
// queue fills, and lets the sequencer run ahead when the input side idles.
// The sequencer executes one tick per cycle whenever its output register is
// free or being drained, so back-to-back ticks flow at full rate.
//
// The timing registers reset to the standard slot lengths and are written
// through the configuration channel, which never stalls. Writes are meant to
// happen while the core is idle.
module one_wire_bus_master_core #(
	parameter int unsigned TIMER_BITS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	owbm_tick_if.sink     tick,
	owbm_cfg_if.sink      cfg,
	owbm_result_if.source result
);

	owbm_pkg::cmd_t front_item;
	logic           front_valid;
	logic           front_ready;
	owbm_pkg::cmd_t queue_item;
	logic           queue_valid;
	logic           queue_ready;

	// Accept and decode ticks.
	owbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	// Decouple the front end from the sequencer.
	owbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (queue_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	// Run the bus slots and present the result of every tick.
	owbm_engine #(
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (queue_item),
		.item_valid (queue_valid),
		.item_ready (queue_ready),
		.cfg        (cfg),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== sv/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the result channel of the bus master core.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       drive_low,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] read_data
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(read_data))
		else $error("result data changed while stalled");

	// An operation finishes only by returning to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// The wire is pulled low only during an operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("wire driven low while idle");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.drive_low (result.drive_low),
	.busy_res  (result.busy_res),
	.done_res  (result.done_res),
	.read_data (result.read_data)
);

`default_nettype wire
